FILE: rtl/lmsgd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmsgd_pkg
// Shared item types, widths and datapath step codes for the linear model
// update block.
// ---------------------------------------------------------------------------
package lmsgd_pkg;

  localparam int FIELD_BITS = 16;
  localparam int WORD_BITS  = 32;
  localparam int PROD_BITS  = WORD_BITS + FIELD_BITS;

  localparam logic [WORD_BITS-1:0] WEIGHT_RESET = WORD_BITS'(1);

  typedef struct packed {
    logic [FIELD_BITS-1:0] feature_a;
    logic [FIELD_BITS-1:0] feature_b;
    logic [FIELD_BITS-1:0] label;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] hypothesis_value;
    logic [WORD_BITS-1:0] error_value;
    logic [WORD_BITS-1:0] new_weight_a;
    logic [WORD_BITS-1:0] new_weight_b;
    logic [WORD_BITS-1:0] new_bias;
  } out_item_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_MUL_A,
    STEP_MUL_B,
    STEP_SUM,
    STEP_ERR,
    STEP_UPD_A,
    STEP_UPD_B,
    STEP_FIN
  } step_t;

  typedef struct packed {
    logic  load;
    step_t step;
    logic  publish;
  } dp_cmd_t;

endpackage

FILE: rtl/lmsgd_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmsgd_datapath
// Sample registers, model weights, one shared 32x16 multiplier with a
// product register, and the result register.
// ---------------------------------------------------------------------------
module lmsgd_datapath #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  lmsgd_pkg::dp_cmd_t  cmd,
  input  lmsgd_pkg::in_item_t in_item,
  output lmsgd_pkg::out_item_t out_item
);

  localparam int KEEP_BITS = (SAMPLE_BITS < lmsgd_pkg::FIELD_BITS) ?
                             SAMPLE_BITS : lmsgd_pkg::FIELD_BITS;
  localparam logic [lmsgd_pkg::FIELD_BITS-1:0] SAMPLE_MASK =
    lmsgd_pkg::FIELD_BITS'((33'd1 << KEEP_BITS) - 33'd1);

  logic [lmsgd_pkg::FIELD_BITS-1:0] xa;
  logic [lmsgd_pkg::FIELD_BITS-1:0] xb;
  logic [lmsgd_pkg::FIELD_BITS-1:0] y;
  logic [lmsgd_pkg::WORD_BITS-1:0]  w0;
  logic [lmsgd_pkg::WORD_BITS-1:0]  w1;
  logic [lmsgd_pkg::WORD_BITS-1:0]  w2;
  logic [lmsgd_pkg::WORD_BITS-1:0]  prod;
  logic [lmsgd_pkg::WORD_BITS-1:0]  h;
  logic [lmsgd_pkg::WORD_BITS-1:0]  e;
  logic [lmsgd_pkg::WORD_BITS-1:0]  mul_a;
  logic [lmsgd_pkg::FIELD_BITS-1:0] mul_b;
  logic [lmsgd_pkg::WORD_BITS-1:0]  mul_full;
  logic [lmsgd_pkg::WORD_BITS-1:0]  w1_next;

  always_comb begin
    case (cmd.step)
      lmsgd_pkg::STEP_MUL_A: begin
        mul_a = w0;
        mul_b = xa;
      end
      lmsgd_pkg::STEP_MUL_B: begin
        mul_a = w1;
        mul_b = xb;
      end
      lmsgd_pkg::STEP_UPD_A: begin
        mul_a = e;
        mul_b = xa;
      end
      default: begin
        mul_a = e;
        mul_b = xb;
      end
    endcase
  end

  assign mul_full = mul_a * lmsgd_pkg::WORD_BITS'(mul_b);
  assign w1_next  = w1 - prod;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xa <= in_item.feature_a & SAMPLE_MASK;
      xb <= in_item.feature_b & SAMPLE_MASK;
      y  <= in_item.label & SAMPLE_MASK;
    end
    case (cmd.step)
      lmsgd_pkg::STEP_MUL_A: prod <= mul_full;
      lmsgd_pkg::STEP_MUL_B: begin
        prod <= mul_full;
        h    <= prod + w2;
      end
      lmsgd_pkg::STEP_SUM:   h <= h + prod;
      lmsgd_pkg::STEP_ERR:   e <= h - lmsgd_pkg::WORD_BITS'(y);
      lmsgd_pkg::STEP_UPD_A: prod <= mul_full;
      lmsgd_pkg::STEP_UPD_B: prod <= mul_full;
      default: ;
    endcase
    if (cmd.publish) begin
      out_item.hypothesis_value <= h;
      out_item.error_value      <= e;
      out_item.new_weight_a     <= w0;
      out_item.new_weight_b     <= w1_next;
      out_item.new_bias         <= w2;
    end
  end

  // model weights
  always_ff @(posedge clk) begin
    if (rst) begin
      w0 <= lmsgd_pkg::WEIGHT_RESET;
      w1 <= lmsgd_pkg::WEIGHT_RESET;
      w2 <= lmsgd_pkg::WEIGHT_RESET;
    end else begin
      if (cmd.step == lmsgd_pkg::STEP_UPD_B) begin
        w0 <= w0 - prod;
        w2 <= w2 - e;
      end
      if (cmd.publish) begin
        w1 <= w1_next;
      end
    end
  end

endmodule

FILE: rtl/lmsgd_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmsgd_ctrl
// Sequencer for the update steps and the handshakes of both channels.
// ---------------------------------------------------------------------------
module lmsgd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lmsgd_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_ERR,
    S_UPD_A,
    S_UPD_B,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.publish = (state == S_DONE) && out_free;
    case (state)
      S_MUL_A: cmd.step = lmsgd_pkg::STEP_MUL_A;
      S_MUL_B: cmd.step = lmsgd_pkg::STEP_MUL_B;
      S_SUM:   cmd.step = lmsgd_pkg::STEP_SUM;
      S_ERR:   cmd.step = lmsgd_pkg::STEP_ERR;
      S_UPD_A: cmd.step = lmsgd_pkg::STEP_UPD_A;
      S_UPD_B: cmd.step = lmsgd_pkg::STEP_UPD_B;
      S_DONE:  cmd.step = lmsgd_pkg::STEP_FIN;
      default: cmd.step = lmsgd_pkg::STEP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_MUL_A;
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: state <= S_SUM;
        S_SUM:   state <= S_ERR;
        S_ERR:   state <= S_UPD_A;
        S_UPD_A: state <= S_UPD_B;
        S_UPD_B: state <= S_DONE;
        S_DONE:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/linear_model_sgd_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_model_sgd_update
// One stochastic gradient step of a two-feature linear model with bias.
// ---------------------------------------------------------------------------
// Usage:
//   in_item carries feature_a, feature_b and label; out_item carries the
//   hypothesis, the error and the updated weights and bias. Both channels
//   use valid/ready; an item moves when both are high at a clock edge.
//   Each accepted item yields exactly one result item.
//   One 32x16 multiplier is shared by the four products of a step, and the
//   error products depend on the finished hypothesis, so the sequencer
//   visits seven steps per item and takes no new item until it is idle again.
//   The result register holds one finished item, so the next input item is
//   taken while it waits. If the receiver stalls, the following item is
//   computed and then held in its last step until the register frees.
//   Reset (rst, synchronous) returns the sequencer to idle, drops any
//   pending result and sets both weights and the bias to one.
//   Inputs are reduced to their low SAMPLE_BITS bits before use.
// ---------------------------------------------------------------------------
module linear_model_sgd_update #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lmsgd_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lmsgd_pkg::out_item_t out_item
);

  lmsgd_pkg::dp_cmd_t cmd;

  lmsgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lmsgd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

FILE: rtl/lmsgd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmsgd_checker
// Port-level checks for the linear model update block.
// ---------------------------------------------------------------------------
module lmsgd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input lmsgd_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input lmsgd_pkg::out_item_t out_item
);

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input item taken while a step is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result item changed while stalled");

endmodule

bind linear_model_sgd_update lmsgd_checker u_lmsgd_checker (.*);

FILE: verif/linear_model_sgd_update_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_model_sgd_update_tb
// Checks the linear model update block item by item. Directed samples hit
// the field extremes and wrapping cases, then 400 random samples follow
// with random idling on both channels. A local copy of the weights and bias
// predicts each result, and every result is compared field by field.
// ---------------------------------------------------------------------------
module linear_model_sgd_update_tb;

  typedef logic [lmsgd_pkg::FIELD_BITS-1:0] field_t;
  typedef logic [lmsgd_pkg::WORD_BITS-1:0]  word_t;

  typedef struct {
    lmsgd_pkg::in_item_t sample;
    bit                  drain_first;
  } sample_entry_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  lmsgd_pkg::in_item_t  in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  lmsgd_pkg::out_item_t out_item;

  sample_entry_t        sample_queue[$];
  lmsgd_pkg::out_item_t predicted_models[$];
  word_t                weight_a, weight_b, bias;
  int unsigned          mismatches = 0;
  int unsigned          tx_pause   = 0;
  int unsigned          rx_pause   = 0;
  bit                   tx_calm    = 1'b0;
  bit                   rx_calm    = 1'b0;

  linear_model_sgd_update dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned pick_pause(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_sample(field_t a, field_t b, field_t y, bit drain);
    sample_entry_t e;
    e.sample.feature_a = a;
    e.sample.feature_b = b;
    e.sample.label     = y;
    e.drain_first      = drain;
    sample_queue.push_back(e);
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Driver: offer the next sample and update the predicted model on accept
  always @(posedge clk) begin : driver
    word_t                xa, xb, yv, hyp, err;
    lmsgd_pkg::out_item_t want;
    logic                 next_valid;
    if (rst) begin
      in_valid <= 1'b0;
      weight_a = lmsgd_pkg::WEIGHT_RESET;
      weight_b = lmsgd_pkg::WEIGHT_RESET;
      bias     = lmsgd_pkg::WEIGHT_RESET;
      tx_pause = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        xa  = lmsgd_pkg::WORD_BITS'(in_item.feature_a);
        xb  = lmsgd_pkg::WORD_BITS'(in_item.feature_b);
        yv  = lmsgd_pkg::WORD_BITS'(in_item.label);
        hyp = weight_a * xa + weight_b * xb + bias;
        err = hyp - yv;
        weight_a = weight_a - err * xa;
        weight_b = weight_b - err * xb;
        bias     = bias - err;
        want.hypothesis_value = hyp;
        want.error_value      = err;
        want.new_weight_a     = weight_a;
        want.new_weight_b     = weight_b;
        want.new_bias         = bias;
        predicted_models.push_back(want);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (tx_pause > 0) begin
          tx_pause--;
        end else if (sample_queue.size() > 0 &&
                     (!sample_queue[0].drain_first || predicted_models.size() == 0)) begin
          in_item <= sample_queue[0].sample;
          sample_queue.pop_front();
          next_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          tx_pause = pick_pause(tx_calm);
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: take results and check them against the oldest prediction
  always @(posedge clk) begin : monitor
    lmsgd_pkg::out_item_t want;
    logic                 next_ready;
    if (rst) begin
      out_ready <= 1'b0;
      rx_pause = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_models.size() == 0) begin
          report_mismatch("result with no prediction", out_item.hypothesis_value, '0);
        end else begin
          want = predicted_models.pop_front();
          if (out_item.hypothesis_value !== want.hypothesis_value)
            report_mismatch("hypothesis_value", out_item.hypothesis_value,
                            want.hypothesis_value);
          if (out_item.error_value !== want.error_value)
            report_mismatch("error_value", out_item.error_value, want.error_value);
          if (out_item.new_weight_a !== want.new_weight_a)
            report_mismatch("new_weight_a", out_item.new_weight_a, want.new_weight_a);
          if (out_item.new_weight_b !== want.new_weight_b)
            report_mismatch("new_weight_b", out_item.new_weight_b, want.new_weight_b);
          if (out_item.new_bias !== want.new_bias)
            report_mismatch("new_bias", out_item.new_bias, want.new_bias);
        end
      end
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (rx_pause > 0) begin
        rx_pause--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if (!rx_calm && $urandom_range(0, 4) == 0) rx_pause = pick_pause(rx_calm);
      end
      out_ready <= next_ready;
    end
  end

  initial begin : stimulus
    int unsigned kind;
    field_t      a, b, y;
    // extremes, single features, wrapping and bit patterns
    queue_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
    queue_sample(16'hffff, 16'hffff, 16'hffff, 1'b0);
    queue_sample(16'hffff, 16'h0000, 16'h0000, 1'b0);
    queue_sample(16'h0000, 16'hffff, 16'h0000, 1'b0);
    queue_sample(16'h0000, 16'h0000, 16'hffff, 1'b0);
    queue_sample(16'h0001, 16'h0001, 16'h0000, 1'b0);
    queue_sample(16'h0001, 16'h0001, 16'h0001, 1'b0);
    queue_sample(16'h8000, 16'h8000, 16'h8000, 1'b0);
    queue_sample(16'hffff, 16'hffff, 16'h0000, 1'b0);
    queue_sample(16'haaaa, 16'h5555, 16'haaaa, 1'b1);
    queue_sample(16'h5555, 16'haaaa, 16'h5555, 1'b0);
    queue_sample(16'h7fff, 16'h0001, 16'hffff, 1'b0);
    queue_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
    queue_sample(16'hffff, 16'hffff, 16'hffff, 1'b0);
    queue_sample(16'h0002, 16'hfffe, 16'h8001, 1'b0);
    for (int i = 0; i < 400; i++) begin
      kind = $urandom_range(0, 9);
      a = lmsgd_pkg::FIELD_BITS'($urandom());
      b = lmsgd_pkg::FIELD_BITS'($urandom());
      y = lmsgd_pkg::FIELD_BITS'($urandom());
      if (kind == 6 || kind == 7) begin
        a = lmsgd_pkg::FIELD_BITS'($urandom_range(0, 15));
        b = lmsgd_pkg::FIELD_BITS'($urandom_range(0, 15));
        y = lmsgd_pkg::FIELD_BITS'($urandom_range(0, 15));
      end else if (kind == 8) begin
        a = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        b = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        y = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      end else if (kind == 9) begin
        a = $urandom_range(0, 1) ? 16'h0000 : a;
        b = $urandom_range(0, 1) ? 16'hffff : b;
      end
      queue_sample(a, b, y, i == 0 || $urandom_range(0, 79) == 0);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (sample_queue.size() != 0 || in_valid || predicted_models.size() != 0)
      @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatches == 0 && predicted_models.size() == 0) begin
      $display("linear_model_sgd_update_tb: PASS");
    end else begin
      $display("linear_model_sgd_update_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("linear_model_sgd_update_tb: FAIL");
    $finish;
  end

endmodule
